/* rtl/spectral_bin_mask_limiter_assert.svh */
// Assertion macros shared by the limiter RTL.
`ifndef SPECTRAL_BIN_MASK_LIMITER_ASSERT_SVH
`define SPECTRAL_BIN_MASK_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBML_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sbml_pkg.sv */
package sbml_pkg;

   localparam int BIN_W      = 24;
   localparam int MASK_W     = 25;
   localparam int SQ_W       = 48;
   localparam int PROD_W     = 48;
   localparam int ROOT_W     = 24;
   localparam int REM_W      = 25;
   localparam int SQRT_STEPS = 24;
   localparam int DIV_STEPS  = 24;

   // Pipeline stage indexes
   localparam int ST_MAG     = 0;
   localparam int ST_MUL     = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_RT0     = 3;
   localparam int ST_LVL     = ST_RT0 + SQRT_STEPS;
   localparam int ST_DV0     = ST_LVL + 1;
   localparam int ST_OUT     = ST_DV0 + DIV_STEPS;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic KIND_ORDINARY = 1'b0;
   localparam logic KIND_EDGE     = 1'b1;

   typedef struct packed {
      logic [BIN_W-1:0]  re_mag;
      logic              re_neg;
      logic [BIN_W-1:0]  im_mag;
      logic              im_neg;
      logic              kind;
      logic [MASK_W-1:0] mask;
   } bin_side_type;

endpackage

/* rtl/sbml_sqrt_pipe.sv */
module sbml_sqrt_pipe
   import sbml_pkg::*;
(
   input  logic                  clock,
   input  logic [SQRT_STEPS-1:0] en,
   input  logic [SQ_W-1:0]       x_in,
   output logic [ROOT_W-1:0]     root_out
);

   logic [SQ_W-1:0] rem_ff [SQRT_STEPS];
   logic [SQ_W-1:0] res_ff [SQRT_STEPS];

   // One result bit per stage, remainder form
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
      localparam int K = SQRT_STEPS - 1 - i;
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);
      logic [SQ_W-1:0] x_prev, r_prev, rem_in, res_in;
      logic [SQ_W:0]   trial;

      always_comb begin
         if (i == 0) begin
            x_prev = x_in;
            r_prev = '0;
         end else begin
            x_prev = rem_ff[(i == 0) ? 0 : i - 1];
            r_prev = res_ff[(i == 0) ? 0 : i - 1];
         end
         trial = {1'b0, r_prev} + {1'b0, BIT};
         if ({1'b0, x_prev} >= trial) begin
            rem_in = x_prev - trial[SQ_W-1:0];
            res_in = (r_prev >> 1) + BIT;
         end else begin
            rem_in = x_prev;
            res_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            rem_ff[i] <= rem_in;
            res_ff[i] <= res_in;
         end
      end
   end

   assign root_out = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

/* rtl/sbml_div_pipe.sv */
module sbml_div_pipe
   import sbml_pkg::*;
(
   input  logic                 clock,
   input  logic [DIV_STEPS-1:0] en,
   input  logic [MASK_W-1:0]    divisor_in,
   input  logic [PROD_W-1:0]    dividend_re,
   input  logic [PROD_W-1:0]    dividend_im,
   output logic [BIN_W-1:0]     quot_re,
   output logic [BIN_W-1:0]     quot_im
);

   logic [MASK_W-1:0] dsr_ff [DIV_STEPS];
   logic [PROD_W-1:0] dvd_ff [2][DIV_STEPS];
   logic [REM_W-1:0]  rem_ff [2][DIV_STEPS];
   logic [BIN_W-1:0]  quo_ff [2][DIV_STEPS];

   // Divisor travels with its transaction
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dsr
      always_ff @(posedge clock) begin
         if (en[i]) begin
            dsr_ff[i] <= (i == 0) ? divisor_in : dsr_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // Restoring division, one quotient bit per stage per lane
   for (genvar l = 0; l < 2; l++) begin : g_lane
      for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
         localparam int K = DIV_STEPS - 1 - i;
         logic [PROD_W-1:0] dvd_prev;
         logic [REM_W-1:0]  r_prev, rem_in;
         logic [BIN_W-1:0]  q_prev, quo_in;
         logic [MASK_W-1:0] d_prev;
         logic [REM_W:0]    r_shift;

         always_comb begin
            if (i == 0) begin
               dvd_prev = (l == 0) ? dividend_re : dividend_im;
               r_prev   = {1'b0, dvd_prev[PROD_W-1 -: BIN_W]};
               q_prev   = '0;
               d_prev   = divisor_in;
            end else begin
               dvd_prev = dvd_ff[l][(i == 0) ? 0 : i - 1];
               r_prev   = rem_ff[l][(i == 0) ? 0 : i - 1];
               q_prev   = quo_ff[l][(i == 0) ? 0 : i - 1];
               d_prev   = dsr_ff[(i == 0) ? 0 : i - 1];
            end
            r_shift = {r_prev, dvd_prev[K]};
            if (r_shift >= {1'b0, d_prev}) begin
               rem_in = REM_W'(r_shift - {1'b0, d_prev});
               quo_in = {q_prev[BIN_W-2:0], 1'b1};
            end else begin
               rem_in = r_shift[REM_W-1:0];
               quo_in = {q_prev[BIN_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en[i]) begin
               dvd_ff[l][i] <= dvd_prev;
               rem_ff[l][i] <= rem_in;
               quo_ff[l][i] <= quo_in;
            end
         end
      end
   end

   assign quot_re = quo_ff[0][DIV_STEPS-1];
   assign quot_im = quo_ff[1][DIV_STEPS-1];

endmodule

/* rtl/spectral_bin_mask_limiter.sv */
// The result path runs through 53 register stages.
// Throughput: one bin per cycle while the output is not stalled; every stage takes a new
// transaction each cycle unless it is full and the stage after it holds.
// Most of the stages are the 24-stage square root and the 24-stage two-lane divider.
// Reset (synchronous, active high) clears all stage valid bits; no other state.
`include "spectral_bin_mask_limiter_assert.svh"

module spectral_bin_mask_limiter
   import sbml_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [BIN_W-1:0]  req_real_part,
   input  logic signed [BIN_W-1:0]  req_imag_part,
   input  logic [MASK_W-1:0]        req_mask_level,
   input  logic                     req_bin_kind,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [BIN_W-1:0]  rsp_real_out,
   output logic signed [BIN_W-1:0]  rsp_imag_out,
   output logic                     rsp_was_limited
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in, en;

   bin_side_type          side_ff [NUM_STAGES-1];
   bin_side_type          side_in;
   logic [PROD_W-1:0]     prod_re_ff [ST_MUL:ST_LVL];
   logic [PROD_W-1:0]     prod_im_ff [ST_MUL:ST_LVL];
   logic [SQ_W-1:0]       sq_re_ff, sq_im_ff, sum_ff;
   logic [ROOT_W-1:0]     root;
   logic [MASK_W-1:0]     level_ff, level_in;
   logic                  lim_ff [ST_LVL:ST_OUT-1];
   logic                  lim_in;
   logic [BIN_W-1:0]      quot_re, quot_im;
   logic [BIN_W-1:0]      real_out_in, imag_out_in, re_orig, im_orig;
   logic [BIN_W-1:0]      real_out_ff, imag_out_ff;
   logic                  was_limited_ff;

   // Stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      en[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int i = ST_OUT - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_ready = en[ST_MAG];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_in & en) | (valid_ff & ~en);
      end
   end

   // Split the bin into sign and magnitude
   always_comb begin
      side_in.re_neg = req_real_part[BIN_W-1];
      side_in.im_neg = req_imag_part[BIN_W-1];
      side_in.re_mag = req_real_part[BIN_W-1] ? BIN_W'(-req_real_part)
                                              : BIN_W'(req_real_part);
      side_in.im_mag = req_imag_part[BIN_W-1] ? BIN_W'(-req_imag_part)
                                              : BIN_W'(req_imag_part);
      side_in.kind   = req_bin_kind;
      side_in.mask   = req_mask_level;
   end

   // Side data rides along every stage up to the output
   for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[i]) begin
            side_ff[i] <= (i == 0) ? side_in : side_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // Squares and mask products
   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         sq_re_ff <= SQ_W'(side_ff[ST_MAG].re_mag) * SQ_W'(side_ff[ST_MAG].re_mag);
         sq_im_ff <= SQ_W'(side_ff[ST_MAG].im_mag) * SQ_W'(side_ff[ST_MAG].im_mag);
         prod_re_ff[ST_MUL] <= PROD_W'(side_ff[ST_MAG].re_mag) *
                               PROD_W'(side_ff[ST_MAG].mask);
         prod_im_ff[ST_MUL] <= PROD_W'(side_ff[ST_MAG].im_mag) *
                               PROD_W'(side_ff[ST_MAG].mask);
      end
   end

   for (genvar i = ST_MUL + 1; i <= ST_LVL; i++) begin : g_prod
      always_ff @(posedge clock) begin
         if (en[i]) begin
            prod_re_ff[i] <= prod_re_ff[i-1];
            prod_im_ff[i] <= prod_im_ff[i-1];
         end
      end
   end

   // Energy sum
   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         sum_ff <= sq_re_ff + sq_im_ff;
      end
   end

   sbml_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (en[ST_RT0 +: SQRT_STEPS]),
      .x_in     (sum_ff),
      .root_out (root)
   );

   // Bin level and mask compare
   always_comb begin
      if (side_ff[ST_LVL-1].kind == KIND_EDGE) begin
         level_in = {1'b0, side_ff[ST_LVL-1].re_mag};
      end else begin
         level_in = {root, 1'b0};
      end
      lim_in = level_in > side_ff[ST_LVL-1].mask;
   end

   always_ff @(posedge clock) begin
      if (en[ST_LVL]) begin
         level_ff       <= level_in;
         lim_ff[ST_LVL] <= lim_in;
      end
   end

   for (genvar i = ST_LVL + 1; i < ST_OUT; i++) begin : g_lim
      always_ff @(posedge clock) begin
         if (en[i]) begin
            lim_ff[i] <= lim_ff[i-1];
         end
      end
   end

   sbml_div_pipe u_div (
      .clock       (clock),
      .en          (en[ST_DV0 +: DIV_STEPS]),
      .divisor_in  (level_ff),
      .dividend_re (prod_re_ff[ST_LVL]),
      .dividend_im (prod_im_ff[ST_LVL]),
      .quot_re     (quot_re),
      .quot_im     (quot_im)
   );

   // Restore signs and pick scaled or original parts
   always_comb begin
      re_orig = side_ff[ST_OUT-1].re_neg ? BIN_W'(-side_ff[ST_OUT-1].re_mag)
                                         : side_ff[ST_OUT-1].re_mag;
      im_orig = side_ff[ST_OUT-1].im_neg ? BIN_W'(-side_ff[ST_OUT-1].im_mag)
                                         : side_ff[ST_OUT-1].im_mag;
      real_out_in = re_orig;
      imag_out_in = im_orig;
      if (lim_ff[ST_OUT-1]) begin
         real_out_in = side_ff[ST_OUT-1].re_neg ? BIN_W'(-quot_re) : quot_re;
         if (side_ff[ST_OUT-1].kind == KIND_ORDINARY) begin
            imag_out_in = side_ff[ST_OUT-1].im_neg ? BIN_W'(-quot_im) : quot_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         real_out_ff    <= real_out_in;
         imag_out_ff    <= imag_out_in;
         was_limited_ff <= lim_ff[ST_OUT-1];
      end
   end

   assign rsp_valid       = valid_ff[ST_OUT];
   assign rsp_real_out    = real_out_ff;
   assign rsp_imag_out    = imag_out_ff;
   assign rsp_was_limited = was_limited_ff;

   // Checks
   `SBML_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready,
      valid_ff[ST_MAG], "accepted transaction did not enter the pipeline")
   `SBML_ASSERT_NOW(a_stall_only_full, clock, reset, !req_ready,
      rsp_valid && !rsp_ready, "input stalled without an output stall")
   `SBML_ASSERT_NOW(a_limit_level, clock, reset, valid_ff[ST_LVL] && lim_ff[ST_LVL],
      level_ff != '0, "limited bin with zero level")
   `SBML_ASSERT_NOW(a_quot_bound, clock, reset,
      valid_ff[ST_OUT-1] && lim_ff[ST_OUT-1],
      quot_re <= side_ff[ST_OUT-1].re_mag, "scaled part exceeds input magnitude")

endmodule

/* dv/spectral_bin_mask_limiter_test.sv */
module spectral_bin_mask_limiter_test;
   import sbml_pkg::*;

   localparam int LATENCY    = 53;
   localparam int RAND_ITEMS = 1950;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [BIN_W-1:0]  req_real_part;
   logic signed [BIN_W-1:0]  req_imag_part;
   logic [MASK_W-1:0]        req_mask_level;
   logic                     req_bin_kind;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [BIN_W-1:0]  rsp_real_out;
   logic signed [BIN_W-1:0]  rsp_imag_out;
   logic                     rsp_was_limited;

   typedef struct packed {
      logic signed [BIN_W-1:0] re;
      logic signed [BIN_W-1:0] im;
      logic                    limited;
   } limited_bin_type;

   typedef struct packed {
      logic signed [BIN_W-1:0] re;
      logic signed [BIN_W-1:0] im;
      logic [MASK_W-1:0]       mask;
      logic                    kind;
   } bin_in_type;

   // Directed row: inputs plus an optional hand-typed expectation
   typedef struct packed {
      bin_in_type      stim;
      logic            has_exp;
      limited_bin_type exp;
   } directed_row_type;

   limited_bin_type pending_bins[$];
   int  mismatches;
   int  results_seen;
   int  limited_seen;
   bit  quiet_phase;

   spectral_bin_mask_limiter dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("timeout");
      $display("FAIL spectral_bin_mask_limiter");
      $finish;
   end

   // Floored integer square root, bit-serial
   function automatic logic [47:0] floor_root(logic [48:0] x);
      logic [48:0] r;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
         if ((r | (49'd1 << b)) * (r | (49'd1 << b)) <= x)
            r = r | (49'd1 << b);
      end
      return r[47:0];
   endfunction

   // part * mask / level, truncated toward zero
   function automatic logic signed [BIN_W-1:0] shrink_part(
         logic signed [BIN_W-1:0] part, logic [MASK_W-1:0] mask,
         logic [63:0] level);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (part < 0) ? 64'(-64'(part)) : 64'(part);
      q   = (mag * 64'(mask)) / level;
      return (part < 0) ? BIN_W'(-q) : BIN_W'(q);
   endfunction

   function automatic limited_bin_type limit_bin(bin_in_type b);
      limited_bin_type o;
      logic [63:0] level;
      logic [63:0] are;
      logic [63:0] aim;
      are = (b.re < 0) ? 64'(-64'(b.re)) : 64'(b.re);
      aim = (b.im < 0) ? 64'(-64'(b.im)) : 64'(b.im);
      if (b.kind == KIND_EDGE)
         level = are;
      else
         level = 64'(2) * 64'(floor_root(49'(are * are + aim * aim)));
      o.re = b.re;
      o.im = b.im;
      o.limited = 1'b0;
      if (level > 64'(b.mask)) begin
         o.limited = 1'b1;
         o.re = shrink_part(b.re, b.mask, level);
         if (b.kind == KIND_ORDINARY)
            o.im = shrink_part(b.im, b.mask, level);
      end
      return o;
   endfunction

   function automatic bin_in_type random_bin();
      bin_in_type b;
      int sel;
      b.re   = BIN_W'($urandom);
      b.im   = BIN_W'($urandom);
      b.kind = 1'($urandom_range(0, 1));
      sel    = $urandom_range(0, 9);
      // Many small bins so limiting and passing both occur often
      if (sel < 4) begin
         b.re = BIN_W'($signed(BIN_W'($urandom_range(0, 2000))) - 1000);
         b.im = BIN_W'($signed(BIN_W'($urandom_range(0, 2000))) - 1000);
         b.mask = MASK_W'($urandom_range(0, 3000));
      end else if (sel < 7) begin
         b.mask = MASK_W'($urandom_range(0, 2 ** MASK_W - 1));
      end else if (sel == 7) begin
         b.mask = MASK_W'($urandom_range(0, 255));
      end else begin
         b.mask = MASK_W'($urandom) >> $urandom_range(0, 24);
      end
      return b;
   endfunction

   // Drive one transaction and wait for acceptance
   task automatic send_bin(bin_in_type b);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_real_part  <= b.re;
      req_imag_part  <= b.im;
      req_mask_level <= b.mask;
      req_bin_kind   <= b.kind;
      do @(posedge clock); while (!req_ready);
      pending_bins.push_back(limit_bin(b));
   endtask

   // Result side: random stall bursts, compare against oldest expectation
   initial begin
      int stall;
      limited_bin_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_bins.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result re=%0d im=%0d", rsp_real_out, rsp_imag_out);
            end else begin
               want = pending_bins.pop_front();
               limited_seen += want.limited;
               if (want.re !== rsp_real_out || want.im !== rsp_imag_out ||
                   want.limited !== rsp_was_limited) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp re=%0d im=%0d lim=%0b got re=%0d im=%0d lim=%0b",
                        want.re, want.im, want.limited,
                        rsp_real_out, rsp_imag_out, rsp_was_limited);
               end
            end
         end
         if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, 9);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type r;
      bin_in_type b;
      int guard;
      req_valid      = 1'b0;
      req_real_part  = '0;
      req_imag_part  = '0;
      req_mask_level = '0;
      req_bin_kind   = KIND_ORDINARY;
      mismatches     = 0;
      results_seen   = 0;
      limited_seen   = 0;
      quiet_phase    = 1'b0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table; hand-typed expectations only where obvious
      rows = '{
         // zero bin, zero mask: level zero passes
         '{'{24'sd0, 24'sd0, 25'd0, KIND_ORDINARY}, 1'b1, '{24'sd0, 24'sd0, 1'b0}},
         // zero mask with nonzero level: zeroed (edge bins keep the imaginary part)
         '{'{24'sd100, -24'sd50, 25'd0, KIND_ORDINARY}, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
         '{'{-24'sd7, 24'sd9, 25'd0, KIND_EDGE}, 1'b1, '{24'sd0, 24'sd9, 1'b1}},
         // level equal to mask: not limited
         '{'{24'sd3, 24'sd4, 25'd10, KIND_ORDINARY}, 1'b1, '{24'sd3, 24'sd4, 1'b0}},
         '{'{-24'sd25, 24'sd1, 25'd25, KIND_EDGE}, 1'b1, '{-24'sd25, 24'sd1, 1'b0}},
         // level one above mask
         '{'{24'sd3, 24'sd4, 25'd9, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sd26, 24'sd0, 25'd25, KIND_EDGE}, 1'b0, '0},
         // field extremes
         '{'{24'sh800000, 24'sh800000, 25'h1FFFFFF, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sh7FFFFF, 24'sh7FFFFF, 25'h1FFFFFF, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sh800000, 24'sh7FFFFF, 25'd1, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sh7FFFFF, 24'sh800000, 25'd1, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sh800000, 24'sh800000, 25'd1, KIND_EDGE}, 1'b0, '0},
         '{'{24'sh7FFFFF, 24'sh7FFFFF, 25'h1FFFFFF, KIND_EDGE}, 1'b1,
            '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0}},
         '{'{24'sh800000, 24'sh000001, 25'h7FFFFF, KIND_EDGE}, 1'b0, '0},
         '{'{-24'sd1, -24'sd1, 25'd1, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sd0, -24'sd1000, 25'd999, KIND_ORDINARY}, 1'b0, '0},
         '{'{24'sd0, 24'sh800000, 25'd0, KIND_EDGE}, 1'b1, '{24'sd0, 24'sh800000, 1'b0}},
         '{'{24'sd12345, -24'sd6789, 25'h155555, KIND_ORDINARY}, 1'b0, '0}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send_bin(r.stim);
         if (r.has_exp && limit_bin(r.stim) !== r.exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: typed expectation disagrees", i);
         end
      end
      req_valid <= 1'b0;

      // Hold off until the pipeline drains completely
      guard = 0;
      while (pending_bins.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - 200)
            quiet_phase = 1'b1;
         b = random_bin();
         send_bin(b);
      end
      req_valid <= 1'b0;

      guard = 0;
      while (pending_bins.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (pending_bins.size() != 0)
         mismatches++;

      $display("covered %0d bins (%0d limited), directed extremes and random mix",
         results_seen, limited_seen);
      if (mismatches == 0)
         $display("PASS spectral_bin_mask_limiter");
      else
         $display("FAIL spectral_bin_mask_limiter");
      $finish;
   end

endmodule
